/* rtl/i420rgb_pkg.sv */
// Shared types and constants of the I420 frame store and RGB converter.
`timescale 1ns / 1ps

package i420rgb_pkg;

  localparam int unsigned WIDTH_W   = 9;
  localparam int unsigned HEIGHT_W  = 8;
  localparam int unsigned BADDR_W   = 17;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned LUMA_W    = WIDTH_W + HEIGHT_W;
  localparam int unsigned PLANE_W   = LUMA_W + 1;
  localparam int unsigned CIDX_W    = LUMA_W - 1;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = WIDTH_W;
  localparam int unsigned ACC_W     = 20;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_CONVERT = 1'b1
  } op_e;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 9'd320;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 8'd240;

  // BT.601 studio-range weights in fixed point with 8 fractional bits.
  localparam logic signed [ACC_W-1:0] COEF_Y   = 20'sd298;
  localparam logic signed [ACC_W-1:0] COEF_RV  = 20'sd408;
  localparam logic signed [ACC_W-1:0] COEF_GU  = 20'sd100;
  localparam logic signed [ACC_W-1:0] COEF_GV  = 20'sd208;
  localparam logic signed [ACC_W-1:0] COEF_BU  = 20'sd516;
  localparam logic signed [ACC_W-1:0] ROUND    = 20'sd128;
  localparam logic signed [ACC_W-1:0] C_BIAS   = 20'sd128;
  localparam logic [PIX_W-1:0]        PIX_MAX  = 8'd255;

  typedef struct packed {
    op_e                 op;
    logic [BADDR_W-1:0]  byte_address;
    logic [PIX_W-1:0]    byte_value;
    logic [WIDTH_W-1:0]  pixel_col;
    logic [HEIGHT_W-1:0] pixel_row;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } out_item_t;

endpackage

/* rtl/i420rgb_frame_mem.sv */
// Single-port byte memory that holds the planar frame, registered read.
`timescale 1ns / 1ps

module i420rgb_frame_mem #(
  parameter int unsigned DEPTH = 115200
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [7:0]               wdata_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/i420_frame_to_rgb_converter.sv */
// Top level: I420 frame store with YUV to RGB conversion using BT.601 studio-range weights.
// A write beat is accepted, then the memory write follows; ready returns after it.
// A convert beat goes through address math, three reads of the one frame memory
// port (Y, U, V), a product stage and a sum/clamp stage; the result is registered.
// The output register lets the next beat be accepted while a result waits.
// Reset clears the control state and sets the size to 320x240; frame bytes are not cleared.
`timescale 1ns / 1ps

module i420_frame_to_rgb_converter #(
  parameter int unsigned MAX_WIDTH  = 320,
  parameter int unsigned MAX_HEIGHT = 240
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [i420rgb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [i420rgb_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  i420rgb_pkg::in_item_t                in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output i420rgb_pkg::out_item_t               out_data_o
);

  import i420rgb_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * 3 / 2;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CALC = 3'd1;
  localparam logic [2:0] ST_RD_Y = 3'd2;
  localparam logic [2:0] ST_RD_U = 3'd3;
  localparam logic [2:0] ST_RD_V = 3'd4;
  localparam logic [2:0] ST_PROD = 3'd5;
  localparam logic [2:0] ST_SUM  = 3'd6;

  function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [ACC_W-1:0] acc);
    logic [PIX_W-1:0] res;
    if (acc[ACC_W-1]) begin
      res = '0;
    end else if (|acc[ACC_W-2:2*PIX_W]) begin
      res = PIX_MAX;
    end else begin
      res = acc[2*PIX_W-1:PIX_W];
    end
    return res;
  endfunction

  logic [2:0]          state_q, state_d;
  logic [WIDTH_W-1:0]  frame_width_q;
  logic [HEIGHT_W-1:0] frame_height_q;
  in_item_t            item_q;

  logic [WIDTH_W-1:0]  w_sat, w_even, w_eff, w_m1, col_c;
  logic [HEIGHT_W-1:0] h_sat, h_even, h_eff, h_m1, row_c;
  logic [LUMA_W-1:0]   luma_now, luma_q, yaddr_q;
  logic [PLANE_W-1:0]  frame_bytes, uaddr, vaddr;
  logic [CIDX_W-1:0]   cidx_q;
  logic [WIDTH_W-1:0]  col_q;
  logic [HEIGHT_W-1:0] row_q;
  logic                in_frame;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  logic [PIX_W-1:0]    mem_rdata;
  logic [PIX_W-1:0]    y_q, u_q;

  logic signed [ACC_W-1:0] y_x, u_x, v_x;
  logic signed [ACC_W-1:0] py_q, prv_q, pgu_q, pgv_q, pbu_q;
  logic signed [ACC_W-1:0] acc_r, acc_g, acc_b;

  logic      out_valid_q;
  out_item_t out_data_q;
  logic      out_load;

  // Effective size: saturate to the maximum, force even, at least two.
  assign w_sat  = (32'(frame_width_q) > MAX_WIDTH) ? WIDTH_W'(MAX_WIDTH) : frame_width_q;
  assign w_even = {w_sat[WIDTH_W-1:1], 1'b0};
  assign w_eff  = (w_even == '0) ? WIDTH_W'(2) : w_even;
  assign h_sat  = (32'(frame_height_q) > MAX_HEIGHT) ? HEIGHT_W'(MAX_HEIGHT)
                                                     : frame_height_q;
  assign h_even = {h_sat[HEIGHT_W-1:1], 1'b0};
  assign h_eff  = (h_even == '0) ? HEIGHT_W'(2) : h_even;
  assign w_m1   = w_eff - WIDTH_W'(1);
  assign h_m1   = h_eff - HEIGHT_W'(1);

  assign luma_now    = LUMA_W'(w_eff) * LUMA_W'(h_eff);
  assign frame_bytes = PLANE_W'(luma_now) + PLANE_W'(luma_now >> 1);
  assign in_frame    = (PLANE_W'(item_q.byte_address) < frame_bytes) &&
                       (32'(item_q.byte_address) < STORE_DEPTH);

  assign col_c = (item_q.pixel_col > w_m1) ? w_m1 : item_q.pixel_col;
  assign row_c = (item_q.pixel_row > h_m1) ? h_m1 : item_q.pixel_row;

  assign uaddr = PLANE_W'(luma_q) + PLANE_W'(cidx_q);
  assign vaddr = PLANE_W'(luma_q) + PLANE_W'(luma_q >> 2) + PLANE_W'(cidx_q);

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_load    = (state_q == ST_SUM) && (!out_valid_q || out_ready_i);

  always_comb begin
    mem_we   = 1'b0;
    mem_addr = ADDR_W'(yaddr_q);
    case (state_q)
      ST_CALC: begin
        mem_we   = (item_q.op == OP_WRITE) && in_frame;
        mem_addr = ADDR_W'(item_q.byte_address);
      end
      ST_RD_Y: mem_addr = ADDR_W'(yaddr_q);
      ST_RD_U: mem_addr = ADDR_W'(uaddr);
      ST_RD_V: mem_addr = ADDR_W'(vaddr);
      default: mem_addr = ADDR_W'(yaddr_q);
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CALC;
      ST_CALC: state_d = (item_q.op == OP_WRITE) ? ST_IDLE : ST_RD_Y;
      ST_RD_Y: state_d = ST_RD_U;
      ST_RD_U: state_d = ST_RD_V;
      ST_RD_V: state_d = ST_PROD;
      ST_PROD: state_d = ST_SUM;
      ST_SUM:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      frame_width_q  <= WIDTH_RESET;
      frame_height_q <= HEIGHT_RESET;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
          REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  i420rgb_frame_mem #(
    .DEPTH (STORE_DEPTH)
  ) u_frame_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (item_q.byte_value),
    .rdata_o (mem_rdata)
  );

  assign y_x = ACC_W'($signed({1'b0, y_q}));
  assign u_x = ACC_W'($signed({1'b0, u_q})) - C_BIAS;
  assign v_x = ACC_W'($signed({1'b0, mem_rdata})) - C_BIAS;

  assign acc_r = py_q + prv_q + ROUND;
  assign acc_g = py_q - pgu_q - pgv_q + ROUND;
  assign acc_b = py_q + pbu_q + ROUND;

  // Datapath registers; the read data of each plane arrives in the cycle after its address.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    case (state_q)
      ST_CALC: begin
        luma_q  <= luma_now;
        yaddr_q <= LUMA_W'(row_c) * LUMA_W'(w_eff) + LUMA_W'(col_c);
        col_q   <= col_c;
        row_q   <= row_c;
      end
      ST_RD_Y: cidx_q <= CIDX_W'(w_eff[WIDTH_W-1:1]) * CIDX_W'(row_q[HEIGHT_W-1:1])
                         + CIDX_W'(col_q[WIDTH_W-1:1]);
      ST_RD_U: y_q <= mem_rdata;
      ST_RD_V: u_q <= mem_rdata;
      ST_PROD: begin
        py_q  <= COEF_Y * y_x;
        prv_q <= COEF_RV * v_x;
        pgu_q <= COEF_GU * u_x;
        pgv_q <= COEF_GV * v_x;
        pbu_q <= COEF_BU * u_x;
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_q.red   <= clamp_pix(acc_r);
      out_data_q.green <= clamp_pix(acc_g);
      out_data_q.blue  <= clamp_pix(acc_b);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* rtl/i420rgb_checker.sv */
// Port-level checks of the I420 to RGB converter, bound to its top level.
`timescale 1ns / 1ps

module i420rgb_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input i420rgb_pkg::in_item_t             in_data_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input i420rgb_pkg::out_item_t            out_data_o
);

  import i420rgb_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // A result beat that is not taken stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed before it was taken");

  // A write gives no result and keeps the input busy while it is written, then frees it.
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.op == OP_WRITE && !out_valid_o
      |=> !out_valid_o && !in_ready_o ##1 !out_valid_o && in_ready_o)
    else $error("write beat produced a result or stalled too long");

  // A convert with an empty output shows its result after the address, read, product and sum states.
  a_convert_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.op == OP_CONVERT && !out_valid_o |-> ##7 out_valid_o)
    else $error("convert result missing");

  // A new result only comes out of a busy period.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while the input side was idle");

endmodule

bind i420_frame_to_rgb_converter i420rgb_checker u_i420rgb_checker (.*);

/* test/i420_frame_to_rgb_converter_test.sv */
// Self-checking testbench for the I420 frame store and BT.601 RGB converter.
`timescale 1ns / 1ps

module i420_frame_to_rgb_converter_test;
  import i420rgb_pkg::*;

  localparam int MAX_W = 320;
  localparam int MAX_H = 240;
  localparam int STORE_DEPTH = MAX_W * MAX_H * 3 / 2;
  localparam int SETTLE_CYCLES = 12;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_BEATS = 80;
  localparam int NUM_PHASES = 12;
  localparam int NUM_DIRECTED = 23;

  // Register indexes the block does not decode.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct {
    op_e op;
    int  addr;
    int  value;
    int  col;
    int  row;
    bit  typed;
    int  red;
    int  green;
    int  blue;
  } directed_row_t;

  typedef struct {
    int         width;
    int         height;
    idle_mode_e mode;
    int         hold;
    bit         pause;
  } phase_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_item_t            out_data_o;

  i420_frame_to_rgb_converter #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Frame contents as the block should hold them, and which bytes were stored.
  logic [7:0]     pixel_store [STORE_DEPTH];
  bit             byte_written [STORE_DEPTH];
  logic [8:0]     width_reg = 9'd320;
  logic [7:0]     height_reg = 8'd240;
  int             geo_w, geo_h, geo_luma, geo_chroma, geo_total;
  out_item_t      rgb_expected [$];
  int             mismatch_count = 0;
  int             useful_beats = 0;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int             hold_request = 0;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{OP_WRITE,        0,   0,   0,   0, 1'b0,   0,   0,   0},
    '{OP_WRITE,    76800, 128,   0,   0, 1'b0,   0,   0,   0},
    '{OP_WRITE,    96000, 128,   0,   0, 1'b0,   0,   0,   0},
    '{OP_CONVERT,      0,   0,   0,   0, 1'b1,   0,   0,   0},
    '{OP_WRITE,        0, 255,   0,   0, 1'b0,   0,   0,   0},
    '{OP_CONVERT,      0,   0,   0,   0, 1'b1, 255, 255, 255},
    '{OP_WRITE,    76800, 255,   0,   0, 1'b0,   0,   0,   0},
    '{OP_WRITE,    96000, 255,   0,   0, 1'b0,   0,   0,   0},
    '{OP_CONVERT,      0,   0,   0,   0, 1'b0,   0,   0,   0},
    '{OP_WRITE,    76800,   0,   0,   0, 1'b0,   0,   0,   0},
    '{OP_WRITE,    96000,   0,   0,   0, 1'b0,   0,   0,   0},
    '{OP_CONVERT,      0,   0,   0,   0, 1'b0,   0,   0,   0},
    '{OP_WRITE,        0,   0,   0,   0, 1'b0,   0,   0,   0},
    '{OP_CONVERT,      0,   0,   0,   0, 1'b0,   0,   0,   0},
    '{OP_WRITE,    76799, 235,   0,   0, 1'b0,   0,   0,   0},
    '{OP_WRITE,    95999,  16,   0,   0, 1'b0,   0,   0,   0},
    '{OP_WRITE,   115199, 240,   0,   0, 1'b0,   0,   0,   0},
    '{OP_CONVERT,      0,   0, 511, 255, 1'b0,   0,   0,   0},
    '{OP_WRITE,   115200,   9,   0,   0, 1'b0,   0,   0,   0},
    '{OP_WRITE,   131071, 255,   0,   0, 1'b0,   0,   0,   0},
    '{OP_WRITE,      321,  16,   0,   0, 1'b0,   0,   0,   0},
    '{OP_CONVERT,      0,   0,   1,   1, 1'b0,   0,   0,   0},
    '{OP_CONVERT,      0,   0, 319, 239, 1'b0,   0,   0,   0}
  };

  phase_t phases [NUM_PHASES] = '{
    '{  2,   2, IDLE_NONE,     200, 1'b0},
    '{511, 255, IDLE_SENDER,     0, 1'b0},
    '{  8,   4, IDLE_RECEIVER,   0, 1'b0},
    '{  7,   5, IDLE_BOTH,       0, 1'b1},
    '{320,   2, IDLE_NONE,       0, 1'b0},
    '{  2, 240, IDLE_SENDER,     0, 1'b0},
    '{  0,   1, IDLE_RECEIVER,   0, 1'b0},
    '{ 16,   6, IDLE_BOTH,       0, 1'b0},
    '{321, 241, IDLE_NONE,       0, 1'b0},
    '{320, 240, IDLE_SENDER,     0, 1'b0},
    '{ 64,  48, IDLE_RECEIVER,   0, 1'b0},
    '{ 33,  17, IDLE_BOTH,       0, 1'b0}
  };

  function automatic int eff_dim(input int reg_val, input int max_val);
    int v;
    v = (reg_val > max_val) ? max_val : reg_val;
    v = v & ~1;
    return (v < 2) ? 2 : v;
  endfunction

  function automatic void update_geometry();
    geo_w = eff_dim(int'(width_reg), MAX_W);
    geo_h = eff_dim(int'(height_reg), MAX_H);
    geo_luma = geo_w * geo_h;
    geo_chroma = (geo_w / 2) * (geo_h / 2);
    geo_total = geo_luma + 2 * geo_chroma;
  endfunction

  // Out-of-frame coordinates saturate to the last column and row.
  function automatic void pixel_addrs(input int col, input int row,
                                      output int y_addr, output int u_addr,
                                      output int v_addr);
    int c, r, cidx;
    c = (col > geo_w - 1) ? geo_w - 1 : col;
    r = (row > geo_h - 1) ? geo_h - 1 : row;
    cidx = (geo_w / 2) * (r / 2) + c / 2;
    y_addr = r * geo_w + c;
    u_addr = geo_luma + cidx;
    v_addr = geo_luma + geo_chroma + cidx;
  endfunction

  function automatic logic [7:0] clamp8(input int acc);
    int q;
    q = acc >>> 8;
    if (q < 0) begin
      q = 0;
    end else if (q > 255) begin
      q = 255;
    end
    return 8'(q);
  endfunction

  function automatic out_item_t convert_pixel(input int col, input int row);
    int ya, ua, va, y, u, v;
    out_item_t px;
    pixel_addrs(col, row, ya, ua, va);
    y = int'(pixel_store[ya]);
    u = int'(pixel_store[ua]) - 128;
    v = int'(pixel_store[va]) - 128;
    px.red   = clamp8(298 * y + 408 * v + 128);
    px.green = clamp8(298 * y - 100 * u - 208 * v + 128);
    px.blue  = clamp8(298 * y + 516 * u + 128);
    return px;
  endfunction

  // Returns whether the byte lands inside the current frame.
  function automatic bit store_byte(input int addr, input logic [7:0] value);
    if (addr < geo_total && addr < STORE_DEPTH) begin
      pixel_store[addr] = value;
      byte_written[addr] = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic in_item_t noise_beat(input op_e op);
    in_item_t beat;
    beat.op = op;
    beat.byte_address = 17'($urandom);
    if ($urandom_range(3) == 0) begin
      beat.byte_value = $urandom_range(1) ? 8'd255 : 8'd0;
    end else begin
      beat.byte_value = 8'($urandom);
    end
    beat.pixel_col = 9'($urandom);
    beat.pixel_row = 8'($urandom);
    return beat;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic send_beat(input in_item_t beat, input bit use_typed,
                           input out_item_t typed_rgb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    if (beat.op == OP_CONVERT) begin
      rgb_expected.push_back(use_typed ? typed_rgb :
                             convert_pixel(int'(beat.pixel_col), int'(beat.pixel_row)));
      useful_beats++;
    end else if (store_byte(int'(beat.byte_address), beat.byte_value)) begin
      useful_beats++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    if (idx == REG_FRAME_WIDTH) begin
      width_reg = data;
    end else if (idx == REG_FRAME_HEIGHT) begin
      height_reg = data[7:0];
    end
    update_geometry();
  endtask

  // A write beat gives no result, so the block may still be busy after the last pixel.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (rgb_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic prime_byte(input int addr);
    in_item_t beat;
    if (!byte_written[addr] || $urandom_range(99) < 30) begin
      beat = noise_beat(OP_WRITE);
      beat.byte_address = 17'(addr);
      send_beat(beat, 1'b0, '0);
    end
  endtask

  // Mostly write-then-convert sequences on random pixels, with stray writes and an optional drain midway.
  task automatic random_phase(input int target, input bit pause_midway);
    int base, col, row, ya, ua, va;
    bit paused;
    in_item_t beat;
    base = useful_beats;
    paused = 1'b0;
    while (useful_beats - base < target) begin
      if (pause_midway && !paused && useful_beats - base >= target / 2) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 12) begin
        send_beat(noise_beat(OP_WRITE), 1'b0, '0);
      end else begin
        if ($urandom_range(99) < 15) begin
          col = $urandom_range(511);
          row = $urandom_range(255);
        end else begin
          col = $urandom_range(geo_w - 1);
          row = $urandom_range(geo_h - 1);
        end
        pixel_addrs(col, row, ya, ua, va);
        prime_byte(ya);
        prime_byte(ua);
        prime_byte(va);
        beat = noise_beat(OP_CONVERT);
        beat.pixel_col = 9'(col);
        beat.pixel_row = 8'(row);
        send_beat(beat, 1'b0, '0);
      end
    end
  endtask

  initial begin : rgb_sink
    out_item_t want;
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        if (rgb_expected.size() == 0) begin
          report_mismatch("pixel beat with no pending conversion");
        end else begin
          want = rgb_expected.pop_front();
          if (out_data_o.red !== want.red) begin
            report_mismatch($sformatf("red got %0d want %0d", out_data_o.red, want.red));
          end
          if (out_data_o.green !== want.green) begin
            report_mismatch($sformatf("green got %0d want %0d", out_data_o.green, want.green));
          end
          if (out_data_o.blue !== want.blue) begin
            report_mismatch($sformatf("blue got %0d want %0d", out_data_o.blue, want.blue));
          end
        end
      end
      if (hold_request != 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    in_item_t beat;
    out_item_t typed_rgb;
    phase_t ph;
    update_geometry();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      beat = '0;
      beat.op = directed_rows[i].op;
      beat.byte_address = 17'(directed_rows[i].addr);
      beat.byte_value = 8'(directed_rows[i].value);
      beat.pixel_col = 9'(directed_rows[i].col);
      beat.pixel_row = 8'(directed_rows[i].row);
      typed_rgb.red = 8'(directed_rows[i].red);
      typed_rgb.green = 8'(directed_rows[i].green);
      typed_rgb.blue = 8'(directed_rows[i].blue);
      send_beat(beat, directed_rows[i].typed, typed_rgb);
    end
    drain();

    foreach (phases[p]) begin
      ph = phases[p];
      send_idle_pct = (ph.mode == IDLE_SENDER) ? 54 : (ph.mode == IDLE_BOTH) ? 12 : 0;
      recv_stall_pct = (ph.mode == IDLE_RECEIVER) ? 54 : (ph.mode == IDLE_BOTH) ? 12 : 0;
      write_reg(REG_FRAME_WIDTH, 9'(ph.width));
      write_reg(REG_FRAME_HEIGHT, {1'($urandom), 8'(ph.height)});
      write_reg((p % 2 == 0) ? REG_SPARE_A : REG_SPARE_B, 9'($urandom));
      cfg_valid_i <= 1'b0;
      hold_request = ph.hold;
      random_phase(PHASE_BEATS, ph.pause);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/i420rgb_pkg.sv
rtl/i420rgb_frame_mem.sv
rtl/i420_frame_to_rgb_converter.sv
rtl/i420rgb_checker.sv
test/i420_frame_to_rgb_converter_test.sv
